// ===== rtl/pcr_pkg.sv =====
// Shared types, constants and helper functions of the column renderer.
package pcr_pkg;

	localparam int unsigned NUM_COLS    = 60;
	localparam int unsigned COL_W       = 6;
	localparam int unsigned SLOT_OFFSET = 30;
	localparam int unsigned SMALL_START = 51;
	localparam int unsigned LARGE_START = 43;

	// floor(x / 60) = (x * RECIP_MUL) >> RECIP_SHIFT, exact for 16-bit x
	localparam logic [15:0] RECIP_MUL   = 16'd34953;
	localparam int unsigned RECIP_SHIFT = 21;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_TURN = 2'd1;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_HANDS = 2'd1,
		MODE_SMALL = 2'd2,
		MODE_LARGE = 2'd3
	} pcr_mode_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SWEEP,
		B_MUL,
		B_CMP,
		B_RD,
		B_OUT
	} pcr_state_t;

	typedef struct packed {
		logic        redraw;
		logic [3:0]  dg0;
		logic [3:0]  dg1;
		logic [3:0]  dg2;
		logic [3:0]  dg3;
		logic [5:0]  hour_col;
		logic [5:0]  min_col;
		logic [15:0] timer;
		logic        rev_start;
	} pcr_item_t;

	localparam logic [2:0] SMALL_FONT [10][5] = '{
		'{3'd7, 3'd5, 3'd5, 3'd5, 3'd7}, '{3'd2, 3'd3, 3'd2, 3'd2, 3'd7},
		'{3'd7, 3'd4, 3'd7, 3'd1, 3'd7}, '{3'd7, 3'd4, 3'd7, 3'd4, 3'd7},
		'{3'd5, 3'd5, 3'd7, 3'd4, 3'd4}, '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7},
		'{3'd7, 3'd1, 3'd7, 3'd5, 3'd7}, '{3'd7, 3'd4, 3'd2, 3'd2, 3'd2},
		'{3'd7, 3'd5, 3'd7, 3'd5, 3'd7}, '{3'd7, 3'd5, 3'd7, 3'd4, 3'd7}
	};

	localparam logic [6:0] LARGE_FONT [10][14] = '{
		'{7'h7F,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h7F},
		'{7'h08,7'h0C,7'h0A,7'h09,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h08,7'h7F},
		'{7'h7F,7'h40,7'h40,7'h40,7'h40,7'h40,7'h40,7'h7F,7'h01,7'h01,7'h01,7'h01,7'h01,7'h7F},
		'{7'h7F,7'h40,7'h40,7'h40,7'h40,7'h40,7'h40,7'h7F,7'h40,7'h40,7'h40,7'h40,7'h40,7'h7F},
		'{7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h7F,7'h40,7'h40,7'h40,7'h40,7'h40,7'h40},
		'{7'h7F,7'h01,7'h01,7'h01,7'h01,7'h01,7'h01,7'h7F,7'h40,7'h40,7'h40,7'h40,7'h40,7'h7F},
		'{7'h7F,7'h01,7'h01,7'h01,7'h01,7'h01,7'h01,7'h7F,7'h41,7'h41,7'h41,7'h41,7'h41,7'h7F},
		'{7'h7F,7'h40,7'h20,7'h20,7'h10,7'h10,7'h08,7'h08,7'h04,7'h04,7'h02,7'h02,7'h01,7'h01},
		'{7'h7F,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h7F,7'h41,7'h41,7'h41,7'h41,7'h41,7'h7F},
		'{7'h7F,7'h41,7'h41,7'h41,7'h41,7'h41,7'h41,7'h7F,7'h40,7'h40,7'h40,7'h40,7'h40,7'h7F}
	};

	// tens digit of a value below 64
	function automatic logic [3:0] tens_of(input logic [5:0] v);
		logic [3:0] t;
		if (v >= 6'd60)      t = 4'd6;
		else if (v >= 6'd50) t = 4'd5;
		else if (v >= 6'd40) t = 4'd4;
		else if (v >= 6'd30) t = 4'd3;
		else if (v >= 6'd20) t = 4'd2;
		else if (v >= 6'd10) t = 4'd1;
		else                 t = 4'd0;
		return t;
	endfunction

	// value below 512 reduced modulo 60, for values up to 299
	function automatic logic [5:0] mod60(input logic [8:0] v);
		logic [8:0] r;
		if (v >= 9'd240)      r = v - 9'd240;
		else if (v >= 9'd180) r = v - 9'd180;
		else if (v >= 9'd120) r = v - 9'd120;
		else if (v >= 9'd60)  r = v - 9'd60;
		else                  r = v;
		return r[5:0];
	endfunction

endpackage

// ===== rtl/pcr_front.sv =====
// Front end: accept input transactions, detect time changes, split digits.
module pcr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [4:0]        hour,
	input  logic [5:0]        minute,
	input  logic [15:0]       timer_count,
	input  logic              revolution_start,
	input  logic              q_full,
	output logic              q_push,
	output pcr_pkg::pcr_item_t q_item
);
	import pcr_pkg::*;

	logic [4:0] shown_hour_q;
	logic [5:0] shown_min_q;
	logic [4:0] hour_m12;
	logic [6:0] hour_x5;
	logic [3:0] h_tens;
	logic [3:0] m_tens;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		if (hour >= 5'd24)      hour_m12 = hour - 5'd24;
		else if (hour >= 5'd12) hour_m12 = hour - 5'd12;
		else                    hour_m12 = hour;
		hour_x5 = {2'b00, hour_m12} * 7'd5;
		h_tens  = tens_of({1'b0, hour});
		m_tens  = tens_of(minute);
	end

	always_comb begin
		q_item.redraw    = (hour != shown_hour_q) || (minute != shown_min_q);
		q_item.dg0       = h_tens;
		q_item.dg1       = 4'(hour - 5'(h_tens * 4'd10));
		q_item.dg2       = m_tens;
		q_item.dg3       = 4'(minute - 6'(m_tens * 4'd10));
		q_item.hour_col  = hour_x5[5:0];
		q_item.min_col   = (minute >= 6'd60) ? (minute - 6'd60) : minute;
		q_item.timer     = timer_count;
		q_item.rev_start = revolution_start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_hour_q <= 5'd31;
			shown_min_q  <= 6'd63;
		end else if (q_push) begin
			shown_hour_q <= hour;
			shown_min_q  <= minute;
		end
	end

endmodule

// ===== rtl/pcr_queue.sv =====
// Two-entry queue between the front end and the back end.
module pcr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pcr_pkg::pcr_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               valid,
	output pcr_pkg::pcr_item_t pop_item
);
	import pcr_pkg::*;

	pcr_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign valid    = (count_q != 2'd0);
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== rtl/pcr_back.sv =====
// Back end: frame store, redraw sweep, slot tracking and result register.
module pcr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pcr_pkg::pcr_mode_t mode,
	input  logic [15:0]        turn_time,
	input  logic               pending_set,
	input  logic               q_valid,
	input  pcr_pkg::pcr_item_t q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        column_bits,
	output logic               slot_advanced
);
	import pcr_pkg::*;

	localparam logic [5:0] G_OFF_S [5] = '{6'd0, 6'd4, 6'd8, 6'd11, 6'd15};
	localparam logic [5:0] G_OFF_L [5] = '{6'd0, 6'd8, 6'd16, 6'd19, 6'd27};
	localparam logic [2:0] G_W_S   [5] = '{3'd3, 3'd3, 3'd2, 3'd3, 3'd3};
	localparam logic [2:0] G_W_L   [5] = '{3'd7, 3'd7, 3'd2, 3'd7, 3'd7};

	pcr_state_t  state_q, state_d;
	pcr_item_t   item_q;
	logic        pending_q;
	logic [3:0]  shown_dg_q [4];
	logic [7:0]  slot_q;
	logic [15:0] latch_q;
	logic [31:0] prod_q;
	logic [19:0] thresh_q;
	logic [6:0]  cnt_q;
	logic        adv_q;
	logic        wr_valid_s1;
	logic [5:0]  wr_addr_s1;
	logic [15:0] mem [NUM_COLS];
	logic [NUM_COLS-1:0] cell_valid_q;
	logic [15:0] rdata_s1;
	logic        rvalid_s1;
	logic        out_valid_q;
	logic [15:0] out_bits_q;
	logic        out_adv_q;

	logic        rd_en;
	logic [5:0]  rd_addr;
	logic        out_load;
	logic [15:0] old_col;
	logic [15:0] new_col;
	logic [7:0]  slot_eff;
	logic [7:0]  slot_next;
	logic        adv;
	logic [3:0]  item_dg [4];
	logic [4:0]  g_en;
	logic [6:0]  t_col;
	logic [6:0]  d_hour;
	logic [6:0]  d_min;
	logic [6:0]  rel_w;
	logic [5:0]  rel;
	logic [5:0]  gi;
	logic        g_hit;
	logic [2:0]  g_sel;
	logic [2:0]  g_i;
	logic [15:0] g_mask;
	logic [15:0] g_bits;
	logic        big_font;

	assign old_col   = rvalid_s1 ? rdata_s1 : 16'h0000;
	assign slot_eff  = item_q.rev_start ? 8'd0 : slot_q;
	assign slot_next = (slot_q == 8'd255) ? slot_q : slot_q + 8'd1;
	assign adv       = {4'd0, item_q.timer} >= thresh_q;
	assign item_dg   = '{item_q.dg0, item_q.dg1, item_q.dg2, item_q.dg3};
	assign big_font  = (mode == MODE_LARGE);

	always_comb begin
		for (int g = 0; g < 4; g++) begin
			g_en[g < 2 ? g : g + 1] = (item_dg[g] != shown_dg_q[g]) || pending_q;
		end
		g_en[2] = pending_q;
	end

	// Column content for the column being rewritten (wr_addr_s1).
	always_comb begin
		t_col  = {1'b0, wr_addr_s1} + 7'd1;
		d_hour = (t_col >= {1'b0, item_q.hour_col}) ? t_col - {1'b0, item_q.hour_col}
			: t_col + 7'(NUM_COLS) - {1'b0, item_q.hour_col};
		d_min  = (t_col >= {1'b0, item_q.min_col}) ? t_col - {1'b0, item_q.min_col}
			: t_col + 7'(NUM_COLS) - {1'b0, item_q.min_col};
		if (d_hour == 7'(NUM_COLS)) d_hour = 7'd0;
		if (d_min == 7'(NUM_COLS))  d_min = 7'd0;

		rel_w = big_font ? 7'(LARGE_START) : 7'(SMALL_START);
		rel_w = ({1'b0, wr_addr_s1} >= rel_w) ? {1'b0, wr_addr_s1} - rel_w
			: {1'b0, wr_addr_s1} + 7'(NUM_COLS) - rel_w;
		rel = rel_w[5:0];

		g_hit = 1'b0;
		g_sel = 3'd0;
		g_i   = 3'd0;
		for (int g = 0; g < 5; g++) begin
			gi = rel - (big_font ? G_OFF_L[g] : G_OFF_S[g]);
			if (rel >= (big_font ? G_OFF_L[g] : G_OFF_S[g])
					&& gi < {3'd0, (big_font ? G_W_L[g] : G_W_S[g])}) begin
				g_hit = 1'b1;
				g_sel = 3'(g);
				g_i   = gi[2:0];
			end
		end

		g_mask = big_font ? 16'hFFFC : 16'h07C0;
		g_bits = 16'h0000;
		if (g_sel == 3'd2) begin
			g_bits = big_font ? 16'h0CC0 : 16'h0280;
		end else if (big_font) begin
			for (int j = 0; j < 14; j++) begin
				g_bits[15-j] = LARGE_FONT[item_dg[g_sel < 3'd2 ? g_sel[1:0]
					: 2'(g_sel - 3'd1)]][j][g_i];
			end
		end else begin
			for (int j = 0; j < 5; j++) begin
				g_bits[10-j] = SMALL_FONT[item_dg[g_sel < 3'd2 ? g_sel[1:0]
					: 2'(g_sel - 3'd1)]][j][g_i[1:0]];
			end
		end

		if (mode == MODE_HANDS) begin
			new_col = 16'h0000;
			if (d_hour == 7'd1)                        new_col = new_col | 16'h000F;
			else if (d_hour == 7'd0 || d_hour == 7'd2) new_col = new_col | 16'h0004;
			if (d_min == 7'd1)                         new_col = new_col | 16'h00FF;
			else if (d_min == 7'd0 || d_min == 7'd2)   new_col = new_col | 16'h0040;
		end else begin
			new_col = pending_q ? 16'h0000 : old_col;
			if (g_hit && g_en[g_sel]) new_col = (new_col & ~g_mask) | g_bits;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					state_d = (q_item.redraw && mode != MODE_OFF) ? B_SWEEP : B_MUL;
				end
			end
			B_SWEEP: if (cnt_q == 7'(NUM_COLS)) state_d = B_MUL;
			B_MUL:   state_d = B_CMP;
			B_CMP:   state_d = B_RD;
			B_RD:    state_d = B_OUT;
			B_OUT:   if (out_load) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == B_IDLE) && q_valid;
		out_load = (state_q == B_OUT) && (!out_valid_q || out_ready);
		rd_en    = 1'b0;
		rd_addr  = cnt_q[5:0];
		unique case (state_q)
			B_SWEEP: rd_en = (cnt_q < 7'(NUM_COLS));
			B_CMP: begin
				rd_en   = adv;
				rd_addr = mod60({1'b0, slot_next} + 9'(SLOT_OFFSET));
			end
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= turn_time * RECIP_MUL;
		if (rd_en) rdata_s1 <= mem[rd_addr];
		if (wr_valid_s1) mem[wr_addr_s1] <= new_col;
		if (q_pop) item_q <= q_item;
		if (state_q == B_MUL) begin
			thresh_q <= 20'(prod_q[31:RECIP_SHIFT] * ({1'b0, slot_eff} + 9'd1));
		end
		wr_addr_s1 <= cnt_q[5:0];
		if (out_load) begin
			out_bits_q <= latch_q;
			out_adv_q  <= adv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			pending_q    <= 1'b1;
			shown_dg_q   <= '{4'd15, 4'd15, 4'd15, 4'd15};
			slot_q       <= 8'd0;
			latch_q      <= 16'h0000;
			cnt_q        <= 7'd0;
			adv_q        <= 1'b0;
			wr_valid_s1  <= 1'b0;
			cell_valid_q <= '0;
			rvalid_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			wr_valid_s1 <= (state_q == B_SWEEP) && (cnt_q < 7'(NUM_COLS));
			if (rd_en) rvalid_s1 <= cell_valid_q[rd_addr];
			if (wr_valid_s1) cell_valid_q[wr_addr_s1] <= 1'b1;
			if (q_pop) cnt_q <= 7'd0;
			else if (state_q == B_SWEEP) cnt_q <= cnt_q + 7'd1;
			if (state_q == B_MUL) begin
				slot_q <= slot_eff;
				if (item_q.redraw) shown_dg_q <= item_dg;
			end
			if (pending_set) pending_q <= 1'b1;
			else if (state_q == B_MUL && item_q.redraw) pending_q <= 1'b0;
			if (state_q == B_CMP) begin
				adv_q <= adv;
				if (adv) slot_q <= slot_next;
			end
			if (state_q == B_RD && adv_q) latch_q <= old_col;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign column_bits   = out_bits_q;
	assign slot_advanced = out_adv_q;

`ifndef SYNTHESIS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == B_IDLE)
		else $error("queue popped while busy");
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid_s1 |-> wr_addr_s1 < 6'(NUM_COLS))
		else $error("sweep write out of range");
	a_sweep_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_SWEEP |-> mode != MODE_OFF && item_q.redraw)
		else $error("sweep without redraw");
	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> state_q == B_IDLE)
		else $error("result loaded without finishing item");
`endif

endmodule

// ===== rtl/pov_clock_column_renderer.sv =====
// Top level of the persistence-of-vision clock column renderer.
// Usage:
//   s_* carries one transaction per timer sample: hour, minute, timer_count
//   and the revolution-start flag. m_* returns one transaction per input:
//   the 16-bit LED column of the current slot and a flag that says whether
//   this sample moved to the next slot.
//   cfg_we/cfg_index/cfg_data write display_mode (index 0) and turn_time
//   (index 1); write only while no sample is in flight.
// Flow:
//   A sample without a time change passes the multiply, compare, read and
//   output states of the back end; one that changes the time in a drawing
//   mode first runs a read-modify-write sweep over the 60 frame store
//   columns. A two-entry queue lets the front accept samples while the back
//   end is busy.
// Reset:
//   Clear the frame store (per-column valid bits), slot counter and column
//   latch; mode returns to hands, turn_time to 60000, redraw pending set.
// Stall:
//   While m_tready is low the result holds in the output register; the back
//   end waits and the queue fills, then s_tready drops.
module pov_clock_column_renderer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // hour[4:0], minute[10:5], timer_count[26:11], zero
	input  logic        s_tuser,  // revolution_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // column_bits[15:0]
	output logic        m_tuser,  // slot_advanced
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import pcr_pkg::*;

	pcr_mode_t   mode_q;
	logic [15:0] turn_time_q;
	logic        q_full;
	logic        q_push;
	logic        q_pop;
	logic        q_valid;
	pcr_item_t   push_item;
	pcr_item_t   pop_item;
	logic        mode_write;

	assign mode_write = cfg_we && (cfg_index == REG_MODE);

	// Hold the configuration registers; unknown indices drop silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_HANDS;
			turn_time_q <= 16'd60000;
		end else if (cfg_we) begin
			if (cfg_index == REG_MODE) mode_q <= pcr_mode_t'(cfg_data[1:0]);
			if (cfg_index == REG_TURN) turn_time_q <= cfg_data;
		end
	end

	pcr_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.hour             (s_tdata[4:0]),
		.minute           (s_tdata[10:5]),
		.timer_count      (s_tdata[26:11]),
		.revolution_start (s_tuser),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_item           (push_item)
	);

	pcr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_item  (pop_item)
	);

	pcr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode_q),
		.turn_time     (turn_time_q),
		.pending_set   (mode_write),
		.q_valid       (q_valid),
		.q_item        (pop_item),
		.q_pop         (q_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.column_bits   (m_tdata),
		.slot_advanced (m_tuser)
	);

endmodule

// ===== verif/tb_pov_clock_column_renderer.sv =====
// Testbench of the POV clock column renderer: directed table, mode digit sweep, random samples vs predictor.
module tb_pov_clock_column_renderer;
	import pcr_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES    = 200;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // hour[4:0], minute[10:5], timer_count[26:11], zero
	logic        s_tuser;   // revolution_start
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // column_bits[15:0]
	logic        m_tuser;   // slot_advanced
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	pov_clock_column_renderer i_dut (.*);

	// one expected column transaction
	typedef struct packed {
		logic [15:0] column_bits;
		logic        slot_advanced;
	} column_t;

	// directed row: chk set when the expected column is typed in
	typedef struct packed {
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [15:0] timer;
		logic        rev;
		logic        chk;
		logic [15:0] col;
		logic        adv;
	} row_t;

	// predictor state
	pcr_mode_t   mdl_mode;
	logic [15:0] mdl_turn;
	logic [15:0] mdl_store [NUM_COLS];
	logic [4:0]  mdl_hour;
	logic [5:0]  mdl_minute;
	logic [3:0]  mdl_digits [4];
	int unsigned mdl_slot;
	logic [15:0] mdl_latch;
	logic        mdl_pending;

	column_t     expected_columns [$];
	int          error_count;
	int          idle_cycles;
	bit          stim_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
		error_count++;
	endtask

	function automatic void put_cell(input int col, input int row, input bit val);
		mdl_store[col % NUM_COLS][row] = val;
	endfunction

	function automatic void or_hand(input int center, input int len, input bit is_min);
		logic [2:0] shape;
		for (int j = 0; j < len; j++) begin
			shape = (j == (is_min ? 6 : 2)) ? 3'd7 : 3'd2;
			for (int i = 0; i < 3; i++)
				if (shape[i]) mdl_store[(center + NUM_COLS - 1 + i) % NUM_COLS][j] = 1'b1;
		end
	endfunction

	// draw digit (or colon when d == 10) at column a; return the next column
	function automatic int put_glyph(input int a, input int d, input bit big, input bit en);
		int w;
		int h;
		bit b;
		w = (d == 10) ? 2 : (big ? 7 : 3);
		h = big ? 14 : 5;
		if (en)
			for (int i = 0; i < w; i++)
				for (int j = 0; j < h; j++) begin
					if (d == 10) begin
						b = big ? (j == 4 || j == 5 || j == 8 || j == 9) : (j == 1 || j == 3);
						put_cell(a + i, j + (big ? 2 : 6), b);
					end else begin
						b = big ? LARGE_FONT[d][j][i] : SMALL_FONT[d][j][i];
						put_cell(a + i, (big ? 15 : 10) - j, b);
					end
				end
		return (a + w + 1) % NUM_COLS;
	endfunction

	function automatic void redraw_store(input int hr, input int mn);
		int dg [4];
		int a;
		bit big;
		dg[0] = hr / 10; dg[1] = hr % 10; dg[2] = mn / 10; dg[3] = mn % 10;
		if (mdl_mode == MODE_HANDS) begin
			foreach (mdl_store[k]) mdl_store[k] = '0;
			or_hand((hr % 12) * 5, 4, 1'b0);
			or_hand(mn % NUM_COLS, 8, 1'b1);
		end else if (mdl_mode != MODE_OFF) begin
			big = (mdl_mode == MODE_LARGE);
			a = big ? LARGE_START : SMALL_START;
			if (mdl_pending) foreach (mdl_store[k]) mdl_store[k] = '0;
			a = put_glyph(a, dg[0], big, dg[0] != mdl_digits[0] || mdl_pending);
			a = put_glyph(a, dg[1], big, dg[1] != mdl_digits[1] || mdl_pending);
			a = put_glyph(a, 10, big, mdl_pending);
			a = put_glyph(a, dg[2], big, dg[2] != mdl_digits[2] || mdl_pending);
			a = put_glyph(a, dg[3], big, dg[3] != mdl_digits[3] || mdl_pending);
		end
		foreach (mdl_digits[k]) mdl_digits[k] = 4'(dg[k]);
		mdl_pending = 1'b0;
	endfunction

	function automatic column_t predict_column(input logic [4:0] hr, input logic [5:0] mn,
			input logic [15:0] timer, input logic rev);
		column_t c;
		c.slot_advanced = 1'b0;
		if (hr != mdl_hour || mn != mdl_minute) begin
			redraw_store(hr, mn);
			mdl_hour = hr;
			mdl_minute = mn;
		end
		if (rev) mdl_slot = 0;
		if (int'(timer) >= (int'(mdl_turn) / NUM_COLS) * (mdl_slot + 1)) begin
			if (mdl_slot < 255) mdl_slot++;
			mdl_latch = mdl_store[(mdl_slot + SLOT_OFFSET) % NUM_COLS];
			c.slot_advanced = 1'b1;
		end
		c.column_bits = mdl_latch;
		return c;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_MODE) begin
			mdl_mode = pcr_mode_t'(val[1:0]);
			mdl_pending = 1'b1;
		end else if (idx == REG_TURN) begin
			mdl_turn = val;
		end
		@(posedge clk);
	endtask

	// hold until every expected column is back, then let the back end drain
	task automatic wait_drain();
		while (expected_columns.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// idle between transactions so valid drops before the next one
	task automatic random_gap();
		int r;
		r = $urandom_range(0, 99);
		repeat (r < 55 ? 1 : (r < 92 ? $urandom_range(2, 5) : $urandom_range(20, 150)))
			@(posedge clk);
	endtask

	// push one sample; the expected column is queued at acceptance
	task automatic send_sample(input logic [4:0] hr, input logic [5:0] mn,
			input logic [15:0] timer, input logic rev, input bit chk,
			input logic [15:0] col, input logic adv);
		column_t c;
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, timer, mn, hr};
		s_tuser  <= rev;
		do @(posedge clk); while (!s_tready);
		c = predict_column(hr, mn, timer, rev);
		if (chk) begin
			if (c.column_bits != col) report_mismatch("table column", c.column_bits, col);
			if (c.slot_advanced != adv) report_mismatch("table advance", c.slot_advanced, adv);
		end
		expected_columns.push_back(c);
		s_tvalid <= 1'b0;
		random_gap();
	endtask

	// random sample; timer mostly walks a revolution so slots advance
	task automatic send_random(inout int unsigned tick, input int unsigned step_max);
		logic [4:0]  hr;
		logic [5:0]  mn;
		logic        rev;
		logic [15:0] timer;
		int          r;
		r = $urandom_range(0, 99);
		hr = (r < 85) ? mdl_hour : 5'($urandom_range(0, 31));
		mn = (r < 70) ? mdl_minute : 6'($urandom_range(0, 63));
		if (r > 95) begin
			hr = 5'($urandom_range(0, 23));
			mn = 6'($urandom_range(0, 59));
		end
		rev = ($urandom_range(0, 99) < 3);
		if (rev) tick = 0;
		tick += $urandom_range(0, step_max);
		timer = ($urandom_range(0, 99) < 5) ? 16'($urandom) : 16'(tick);
		send_sample(hr, mn, timer, rev, 1'b0, '0, 1'b0);
	endtask

	// directed rows: after reset the store is empty, so the first columns read zero
	row_t dir_rows [] = '{
		'{5'd31, 6'd63, 16'd0,     1'b0, 1'b1, 16'h0000, 1'b0},
		'{5'd31, 6'd63, 16'd1000,  1'b0, 1'b1, 16'h0000, 1'b1},
		'{5'd0,  6'd0,  16'd0,     1'b1, 1'b0, 16'h0000, 1'b0},
		'{5'd12, 6'd30, 16'd999,   1'b0, 1'b0, 16'h0000, 1'b0},
		'{5'd23, 6'd59, 16'd65535, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{5'd31, 6'd63, 16'd65535, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{5'd11, 6'd1,  16'd2000,  1'b1, 1'b0, 16'h0000, 1'b0},
		'{5'd24, 6'd60, 16'd30000, 1'b0, 1'b0, 16'h0000, 1'b0}
	};

	// stimulus
	initial begin
		int unsigned tick;
		logic [15:0] turns [4];
		turns     = '{16'd60000, 16'd0, 16'd65535, 16'd59};
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		error_count = 0;
		stim_done = 1'b0;
		mdl_mode = MODE_HANDS;
		mdl_turn = 16'd60000;
		foreach (mdl_store[k]) mdl_store[k] = '0;
		mdl_hour = 5'd31;
		mdl_minute = 6'd63;
		foreach (mdl_digits[k]) mdl_digits[k] = 4'd15;
		mdl_slot = 0;
		mdl_latch = '0;
		mdl_pending = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_sample(dir_rows[i].hour, dir_rows[i].minute, dir_rows[i].timer,
				dir_rows[i].rev, dir_rows[i].chk, dir_rows[i].col, dir_rows[i].adv);

		// each mode with every display digit, plus an ignored register index
		for (int m = 0; m < 4; m++) begin
			wait_drain();
			write_reg(REG_MODE, 16'(m == 3 ? MODE_OFF : m + 1) | 16'hFFFC);
			write_reg(2'd3, 16'hFFFF);
			for (int d = 0; d < 10; d++)
				send_sample(5'(d * 2 + d % 2), 6'(d * 6 + d % 4), 16'(d * 1000),
					1'b0, 1'b0, '0, 1'b0);
		end

		// random phases across modes and slot widths
		for (int ph = 0; ph < 16; ph++) begin
			wait_drain();
			write_reg(REG_MODE, 16'(ph % 4));
			write_reg(REG_TURN, (ph % 5 == 4) ? 16'($urandom) : turns[ph % 4]);
			tick = 0;
			for (int n = 0; n < 88; n++)
				send_random(tick, (mdl_turn / NUM_COLS) * 2 + 2);
		end
		wait_drain();
		stim_done = 1'b1;
	end

	// result side: random stalls, compare in order
	initial begin
		column_t want;
		int r;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (expected_columns.size() == 0) begin
					report_mismatch("unexpected column", m_tdata, 0);
				end else begin
					want = expected_columns.pop_front();
					if (m_tdata != want.column_bits)
						report_mismatch("column_bits", m_tdata, want.column_bits);
					if (m_tuser != want.slot_advanced)
						report_mismatch("slot_advanced", m_tuser, want.slot_advanced);
				end
			end
			r = $urandom_range(0, 99);
			if (r >= 98) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(20, 120)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= (r < 70) ? 1'b1 : (r < 97 ? 1'b0 : m_tready);
			end
		end
	end

	// watchdog on cycles without any accepted transaction; final verdict
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (stim_done) begin
				if (error_count == 0 && expected_columns.size() == 0)
					$display("Test completed successfully");
				else
					$display("Test completed with failures");
				$finish;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule
